// File: rtl/jhmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhmp_pkg
// Shared status codes, chroma codes, marker codes, sampling factor codes and
// the expected SOF0 length for the JPEG header marker parser.
// ----------------------------------------------------------------------------
package jhmp_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOTE  = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  // Chroma format codes
  localparam logic [1:0] FMT_420  = 2'd0;
  localparam logic [1:0] FMT_422  = 2'd1;
  localparam logic [1:0] FMT_444  = 2'd2;
  localparam logic [1:0] FMT_NONE = 2'd3;

  // Marker codes
  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_DQT    = 8'hDB;
  localparam logic [7:0] MK_SOF0   = 8'hC0;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_DHT    = 8'hC4;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_COM    = 8'hFE;

  // Sampling factor codes
  localparam logic [7:0] SF_22 = 8'h22;
  localparam logic [7:0] SF_21 = 8'h21;
  localparam logic [7:0] SF_11 = 8'h11;

  // Expected SOF0 length for three components
  localparam logic [15:0] SOF0_LEN = 16'd17;

endpackage

// File: rtl/jhmp_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhmp_byte_if
// Byte stream channel: one stream byte and its last-byte flag per beat.
// ----------------------------------------------------------------------------
interface jhmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       last_byte;

  modport source (output valid, output stream_byte, output last_byte, input ready);
  modport sink   (input valid, input stream_byte, input last_byte, output ready);
endinterface

// File: rtl/jhmp_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhmp_result_if
// Result channel: parse status, image size and chroma format per beat.
// ----------------------------------------------------------------------------
interface jhmp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [1:0]  chroma_format;

  modport source (output valid, output status, output image_width, output image_height,
                  output chroma_format, input ready);
  modport sink   (input valid, input status, input image_width, input image_height,
                  input chroma_format, output ready);
endinterface

// File: rtl/jhmp_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhmp_cfg_if
// Configuration write channel for the skip_app_segments register.
// ----------------------------------------------------------------------------
interface jhmp_cfg_if;
  logic valid;
  logic ready;
  logic skip_app_segments;

  modport source (output valid, output skip_app_segments, input ready);
  modport sink   (input valid, input skip_app_segments, output ready);
endinterface

// File: rtl/jpeg_header_marker_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_header_marker_parser
// Walks JPEG marker segments byte by byte up to the start of scan.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock. Each accepted byte updates the parse state
// in the same edge, and a result, if the byte causes one, sits in the output
// register from the next cycle on. Bytes keep flowing as long as that
// register is empty or being drained in the same cycle, so the sustained rate
// is one byte per cycle; the only thing that holds the input back is a
// result waiting on the sink.
// One result per file: at SOS, at the first error, or at the last byte. After
// a result the remaining bytes are swallowed until last_byte, which also
// clears the parse state for the next file. The skip register resets to 1
// and is kept across files.
module jpeg_header_marker_parser
  import jhmp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  jhmp_byte_if.sink     byte_i,
  jhmp_cfg_if.sink      cfg_i,
  jhmp_result_if.source result_o
);

  // Parse phase codes
  localparam logic [4:0] PH_SCAN       = 5'd0;
  localparam logic [4:0] PH_PREFIX     = 5'd1;
  localparam logic [4:0] PH_DQT_LH     = 5'd2;
  localparam logic [4:0] PH_DQT_LL     = 5'd3;
  localparam logic [4:0] PH_SKIP       = 5'd4;
  localparam logic [4:0] PH_SOF_LH     = 5'd5;
  localparam logic [4:0] PH_SOF_LL     = 5'd6;
  localparam logic [4:0] PH_SOF_P      = 5'd7;
  localparam logic [4:0] PH_SOF_HH     = 5'd8;
  localparam logic [4:0] PH_SOF_HL     = 5'd9;
  localparam logic [4:0] PH_SOF_WH     = 5'd10;
  localparam logic [4:0] PH_SOF_WL     = 5'd11;
  localparam logic [4:0] PH_SOF_NF     = 5'd12;
  localparam logic [4:0] PH_SOF_COMP   = 5'd13;
  localparam logic [4:0] PH_SOS_LH     = 5'd14;
  localparam logic [4:0] PH_SOS_LL     = 5'd15;
  localparam logic [4:0] PH_SOS_NS     = 5'd16;
  localparam logic [4:0] PH_SOS_BODY   = 5'd17;
  localparam logic [4:0] PH_DHT_LH     = 5'd18;
  localparam logic [4:0] PH_DHT_LL     = 5'd19;
  localparam logic [4:0] PH_DHT_CLASS  = 5'd20;
  localparam logic [4:0] PH_DHT_COUNTS = 5'd21;
  localparam logic [4:0] PH_DHT_SYMS   = 5'd22;
  localparam logic [4:0] PH_APP_LH     = 5'd23;
  localparam logic [4:0] PH_APP_LL     = 5'd24;

  // Parse state
  logic [4:0]  phase_q,   phase_d;
  logic [15:0] seg_len_q, seg_len_d;
  logic [15:0] seg_cnt_q, seg_cnt_d;
  logic [15:0] dht_rem_q, dht_rem_d;
  logic [11:0] dht_sum_q, dht_sum_d;
  logic [15:0] width_q,   width_d;
  logic [15:0] height_q,  height_d;
  logic [7:0]  comp_cnt_q, comp_cnt_d;
  logic [7:0]  samp_q [3];
  logic [7:0]  samp_d [3];
  logic [1:0]  format_q,  format_d;
  logic        note_q,    note_d;
  logic        given_q,   given_d;
  logic        skip_q;

  // Output register
  logic        out_valid_q, out_valid_d;
  logic [1:0]  out_status_q;
  logic [15:0] out_width_q, out_height_q;
  logic [1:0]  out_format_q;

  // Step helpers
  logic        in_beat;
  logic [7:0]  b;
  logic [15:0] len;
  logic [15:0] cnt_inc, cnt_dec;
  logic [11:0] sum_new;
  logic [12:0] table_len;
  logic [15:0] sos_len;
  logic        step_emit;
  logic [1:0]  step_code;
  logic        emit;
  logic [1:0]  emit_code;

  assign in_beat      = byte_i.valid && byte_i.ready;
  assign byte_i.ready = !out_valid_q || result_o.ready;
  assign cfg_i.ready  = 1'b1;

  assign b         = byte_i.stream_byte;
  assign len       = seg_len_q | {8'd0, b};
  assign cnt_inc   = seg_cnt_q + 16'd1;
  assign cnt_dec   = seg_cnt_q - 16'd1;
  assign sum_new   = dht_sum_q + {4'd0, b};
  assign table_len = {1'b0, sum_new} + 13'd17;
  assign sos_len   = {7'd0, comp_cnt_q, 1'b0} + 16'd6;

  // One byte of the marker walk
  always_comb begin
    phase_d    = phase_q;
    seg_len_d  = seg_len_q;
    seg_cnt_d  = seg_cnt_q;
    dht_rem_d  = dht_rem_q;
    dht_sum_d  = dht_sum_q;
    width_d    = width_q;
    height_d   = height_q;
    comp_cnt_d = comp_cnt_q;
    samp_d     = samp_q;
    format_d   = format_q;
    note_d     = note_q;
    step_emit  = 1'b0;
    step_code  = ST_OK;

    case (phase_q)
      PH_SCAN: begin
        if (b == MK_PREFIX) phase_d = PH_PREFIX;
      end
      PH_PREFIX: begin
        // fill bytes keep the prefix; unknown markers resume scanning
        phase_d = PH_SCAN;
        if (b == MK_PREFIX) begin
          phase_d = PH_PREFIX;
        end else if (b == MK_SOI) begin
          phase_d = PH_SCAN;
        end else if (b == MK_DQT) begin
          phase_d = PH_DQT_LH;
        end else if (b == MK_SOF0) begin
          phase_d = PH_SOF_LH;
        end else if (b == MK_SOS) begin
          phase_d = PH_SOS_LH;
        end else if (b == MK_DHT) begin
          phase_d = PH_DHT_LH;
        end else if (b inside {[8'hE0:8'hEF], MK_COM}) begin
          phase_d = PH_APP_LH;
        end else if (b inside {[8'hC1:8'hC3], [8'hC5:8'hC7], [8'hC9:8'hCB],
                               [8'hCD:8'hCF], MK_EOI}) begin
          step_emit = 1'b1;
          step_code = ST_UNSUP;
        end
      end
      PH_DQT_LH, PH_SOF_LH, PH_SOS_LH, PH_DHT_LH, PH_APP_LH: begin
        seg_len_d = {b, 8'd0};
        phase_d   = phase_q + 5'd1;
      end
      PH_DQT_LL, PH_APP_LL: begin
        seg_len_d = len;
        if (len < 16'd2) begin
          step_emit = 1'b1;
          step_code = ST_BAD;
        end else if (phase_q == PH_DQT_LL || skip_q) begin
          seg_cnt_d = len - 16'd2;
          phase_d   = (len == 16'd2) ? PH_SCAN : PH_SKIP;
        end else begin
          phase_d = PH_SCAN;
        end
      end
      PH_SKIP: begin
        seg_cnt_d = cnt_dec;
        if (cnt_dec == 16'd0) phase_d = PH_SCAN;
      end
      PH_SOF_LL: begin
        seg_len_d = len;
        if (len < 16'd2) begin
          step_emit = 1'b1;
          step_code = ST_BAD;
        end else begin
          phase_d = PH_SOF_P;
        end
      end
      PH_SOF_P:  phase_d = PH_SOF_HH;
      PH_SOF_HH: begin
        height_d = {b, 8'd0};
        phase_d  = PH_SOF_HL;
      end
      PH_SOF_HL: begin
        height_d = height_q | {8'd0, b};
        phase_d  = PH_SOF_WH;
      end
      PH_SOF_WH: begin
        width_d = {b, 8'd0};
        phase_d = PH_SOF_WL;
      end
      PH_SOF_WL: begin
        width_d = width_q | {8'd0, b};
        phase_d = PH_SOF_NF;
      end
      PH_SOF_NF: begin
        comp_cnt_d = b;
        if (b != 8'd3) begin
          step_emit = 1'b1;
          step_code = ST_UNSUP;
        end else begin
          seg_cnt_d = 16'd0;
          phase_d   = PH_SOF_COMP;
        end
      end
      PH_SOF_COMP: begin
        // second byte of each component triple carries the factors
        if (seg_cnt_q == 16'd1) samp_d[0] = b;
        if (seg_cnt_q == 16'd4) samp_d[1] = b;
        if (seg_cnt_q == 16'd7) samp_d[2] = b;
        seg_cnt_d = cnt_inc;
        if (cnt_inc >= 16'd9) begin
          if (samp_q[1] != SF_11 || samp_q[2] != SF_11) begin
            step_emit = 1'b1;
            step_code = ST_UNSUP;
          end else if (samp_q[0] != SF_22 && samp_q[0] != SF_21 && samp_q[0] != SF_11) begin
            step_emit = 1'b1;
            step_code = ST_UNSUP;
          end else begin
            if (samp_q[0] == SF_22) begin
              format_d = FMT_420;
            end else begin
              format_d = (samp_q[0] == SF_21) ? FMT_422 : FMT_444;
              if (height_q[3:0] <= 4'd8) note_d = 1'b1;
            end
            if (seg_len_q != SOF0_LEN) begin
              step_emit = 1'b1;
              step_code = ST_BAD;
            end else begin
              phase_d = PH_SCAN;
            end
          end
        end
      end
      PH_SOS_LL: begin
        seg_len_d = len;
        if (len < 16'd2) begin
          step_emit = 1'b1;
          step_code = ST_BAD;
        end else begin
          phase_d = PH_SOS_NS;
        end
      end
      PH_SOS_NS: begin
        comp_cnt_d = b;
        if (b > 8'd3) begin
          step_emit = 1'b1;
          step_code = ST_BAD;
        end else begin
          seg_cnt_d = {7'd0, b, 1'b0} + 16'd3;
          phase_d   = PH_SOS_BODY;
        end
      end
      PH_SOS_BODY: begin
        seg_cnt_d = cnt_dec;
        if (cnt_dec == 16'd0) begin
          step_emit = 1'b1;
          if (seg_len_q != sos_len) step_code = ST_BAD;
          else                      step_code = note_q ? ST_NOTE : ST_OK;
        end
      end
      PH_DHT_LL: begin
        seg_len_d = len;
        if (len <= 16'd2) begin
          step_emit = 1'b1;
          step_code = ST_BAD;
        end else begin
          dht_rem_d = len - 16'd2;
          phase_d   = PH_DHT_CLASS;
        end
      end
      PH_DHT_CLASS: begin
        seg_cnt_d = 16'd0;
        dht_sum_d = 12'd0;
        phase_d   = PH_DHT_COUNTS;
      end
      PH_DHT_COUNTS: begin
        dht_sum_d = sum_new;
        seg_cnt_d = cnt_inc;
        if (cnt_inc >= 16'd16) begin
          if ({3'd0, table_len} > dht_rem_q) begin
            step_emit = 1'b1;
            step_code = ST_BAD;
          end else begin
            dht_rem_d = dht_rem_q - {3'd0, table_len};
            if (sum_new == 12'd0) begin
              phase_d = (dht_rem_q != {3'd0, table_len}) ? PH_DHT_CLASS : PH_SCAN;
            end else begin
              seg_cnt_d = {4'd0, sum_new};
              phase_d   = PH_DHT_SYMS;
            end
          end
        end
      end
      PH_DHT_SYMS: begin
        seg_cnt_d = cnt_dec;
        if (cnt_dec == 16'd0) phase_d = (dht_rem_q != 16'd0) ? PH_DHT_CLASS : PH_SCAN;
      end
      default: phase_d = PH_SCAN;
    endcase
  end

  // Result selection: step result first, else end of file with no result
  assign emit      = in_beat && !given_q && (step_emit || byte_i.last_byte);
  assign emit_code = step_emit ? step_code : ST_BAD;
  assign given_d   = given_q || emit;

  assign out_valid_d = (out_valid_q && !result_o.ready) || emit;

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SCAN;
      seg_len_q  <= '0;
      seg_cnt_q  <= '0;
      dht_rem_q  <= '0;
      dht_sum_q  <= '0;
      width_q    <= '0;
      height_q   <= '0;
      comp_cnt_q <= '0;
      samp_q     <= '{default: '0};
      format_q   <= FMT_NONE;
      note_q     <= 1'b0;
      given_q    <= 1'b0;
    end else if (in_beat) begin
      if (byte_i.last_byte) begin
        // new file starts after the last byte
        phase_q    <= PH_SCAN;
        seg_len_q  <= '0;
        seg_cnt_q  <= '0;
        dht_rem_q  <= '0;
        dht_sum_q  <= '0;
        width_q    <= '0;
        height_q   <= '0;
        comp_cnt_q <= '0;
        samp_q     <= '{default: '0};
        format_q   <= FMT_NONE;
        note_q     <= 1'b0;
        given_q    <= 1'b0;
      end else if (!given_q) begin
        phase_q    <= phase_d;
        seg_len_q  <= seg_len_d;
        seg_cnt_q  <= seg_cnt_d;
        dht_rem_q  <= dht_rem_d;
        dht_sum_q  <= dht_sum_d;
        width_q    <= width_d;
        height_q   <= height_d;
        comp_cnt_q <= comp_cnt_d;
        samp_q     <= samp_d;
        format_q   <= format_d;
        note_q     <= note_d;
        given_q    <= given_d;
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 1'b1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      skip_q <= cfg_i.skip_app_segments;
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output register payload, taken from the post-step state
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= emit_code;
      out_width_q  <= width_d;
      out_height_q <= height_d;
      out_format_q <= format_d;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.status        = out_status_q;
  assign result_o.image_width   = out_width_q;
  assign result_o.image_height  = out_height_q;
  assign result_o.chroma_format = out_format_q;

endmodule

// File: rtl/jhmp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhmp_checker
// Port-level checks on the parser's byte and result channels.
// ----------------------------------------------------------------------------
module jhmp_checker
  import jhmp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  jhmp_byte_if.sink     byte_i,
  jhmp_result_if.source result_o
);

  // Stalled result beat holds its payload
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.ready |=>
      result_o.valid && $stable(result_o.status) && $stable(result_o.image_width) &&
      $stable(result_o.image_height) && $stable(result_o.chroma_format))
    else $error("result beat changed while stalled");

  // A fresh result beat only follows an accepted byte
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (!$past(result_o.valid) || $past(result_o.ready)) |->
      $past(byte_i.valid && byte_i.ready))
    else $error("result beat without an accepted byte");

  // No byte taken while a result waits on the sink
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.ready |-> !byte_i.ready)
    else $error("byte accepted while result stalled");

endmodule

bind jpeg_header_marker_parser jhmp_checker u_jhmp_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .byte_i   (byte_i),
  .result_o (result_o)
);
